[src/clp_pkg.sv]
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int MAX_ITEMS_DEF     = 255;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int DIV_STEPS         = 4;
  localparam int DIV_STAGES        = 32 / DIV_STEPS;
  localparam int VW                = 34;
  localparam logic signed [VW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_CENTER_LON   = 3'd0,
    REG_CENTER_LAT   = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_ALTITUDE     = 3'd3,
    REG_PHASE_OFFSET = 3'd4,
    REG_ITEM_COUNT   = 3'd5
  } clp_reg_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] id;
  } clp_tag_t;

  function automatic logic [31:0] clp_atan(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[src/clp_divider.sv]
// ----------------------------------------------------------------------------
// clp_divider
// Pipelined restoring divider: phase = (index, offset) as a fraction over count.
// ----------------------------------------------------------------------------
module clp_divider import clp_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  item_index,
  input  logic [7:0]  item_count,
  input  logic [15:0] phase_offset,
  output logic        out_valid,
  output clp_tag_t    out_tag,
  output logic [31:0] out_phase
);

  localparam logic [7:0] MAX_N = 8'(MAX_ITEMS);

  logic            v   [0:DIV_STAGES];
  clp_tag_t        tag [0:DIV_STAGES];
  logic [8:0]      rem [0:DIV_STAGES];
  logic [31:0]     q   [0:DIV_STAGES];
  logic [7:0]      n;
  logic [31:0]     dvd;

  assign n   = (item_count > MAX_N) ? MAX_N : item_count;
  assign dvd = {phase_offset, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      tag[0].ok <= (n != 8'd0) && (item_index < n);
      tag[0].id <= item_index + 8'd1;
      rem[0]    <= {1'b0, item_index};
      q[0]      <= 32'h0;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [8:0]  rem_next;
    logic [31:0] q_next;

    always_comb begin
      logic [9:0] t;
      rem_next = rem[k];
      q_next   = q[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {rem_next, dvd[31 - DIV_STEPS*k - j]};
        if (t >= {2'b00, n}) begin
          t = t - {2'b00, n};
          q_next[31 - DIV_STEPS*k - j] = 1'b1;
        end
        rem_next = t[8:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        tag[k+1] <= tag[k];
        rem[k+1] <= rem_next;
        q[k+1]   <= q_next;
      end
    end
  end

  assign out_valid = v[DIV_STAGES];
  assign out_tag   = tag[DIV_STAGES];
  assign out_phase = q[DIV_STAGES];

endmodule

[src/clp_cordic.sv]
// ----------------------------------------------------------------------------
// clp_cordic
// Rotation-mode CORDIC, one stage per register, quadrant carried alongside.
// ----------------------------------------------------------------------------
module clp_cordic import clp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  clp_tag_t             in_tag,
  input  logic [31:0]          in_phase,
  output logic                 out_valid,
  output clp_tag_t             out_tag,
  output logic [1:0]           out_quad,
  output logic signed [VW-1:0] out_x,
  output logic signed [VW-1:0] out_y
);

  logic                 v    [0:CORDIC_STAGES];
  clp_tag_t             tag  [0:CORDIC_STAGES];
  logic [1:0]           quad [0:CORDIC_STAGES];
  logic signed [VW-1:0] x    [0:CORDIC_STAGES];
  logic signed [VW-1:0] y    [0:CORDIC_STAGES];
  logic signed [VW-1:0] z    [0:CORDIC_STAGES];

  always_comb begin
    v[0]    = in_valid;
    tag[0]  = in_tag;
    quad[0] = in_phase[31:30];
    x[0]    = GAIN_Q30;
    y[0]    = '0;
    z[0]    = $signed({4'b0000, in_phase[29:0]});
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [VW-1:0] ANG = $signed({2'b00, clp_atan(i)});
    logic signed [VW-1:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        tag[i+1]  <= tag[i];
        quad[i+1] <= quad[i];
        if (!z[i][VW-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ANG;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ANG;
        end
      end
    end
  end

  assign out_valid = v[CORDIC_STAGES];
  assign out_tag   = tag[CORDIC_STAGES];
  assign out_quad  = quad[CORDIC_STAGES];
  assign out_x     = x[CORDIC_STAGES];
  assign out_y     = y[CORDIC_STAGES];

endmodule

[src/clp_scale.sv]
// ----------------------------------------------------------------------------
// clp_scale
// Quadrant fold, radius multiply, round, center add and saturation.
// ----------------------------------------------------------------------------
module clp_scale import clp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  clp_tag_t             in_tag,
  input  logic [1:0]           in_quad,
  input  logic signed [VW-1:0] in_x,
  input  logic signed [VW-1:0] in_y,
  input  logic [30:0]          radius,
  input  logic signed [31:0]   center_lon,
  input  logic signed [31:0]   center_lat,
  output logic                 out_valid,
  output clp_tag_t             out_tag,
  output logic signed [31:0]   out_lon,
  output logic signed [31:0]   out_lat
);

  localparam int PW = VW + 32;
  localparam int RW = PW - 30;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd536870912);
  localparam logic signed [RW:0]   SMAX = (RW+1)'(64'sd2147483647);
  localparam logic signed [RW:0]   SMIN = (RW+1)'(-64'sd2147483648);

  logic                 va, vb;
  clp_tag_t             ta, tb;
  logic signed [VW-1:0] c, s;
  logic signed [PW-1:0] pc, ps;

  function automatic logic signed [31:0] fin(input logic signed [PW-1:0] p,
                                             input logic signed [31:0] ctr);
    logic signed [PW-1:0] r;
    logic signed [RW:0]   sum;
    r   = (p + HALF) >>> 30;
    sum = $signed({r[RW-1], r[RW-1:0]}) + (RW+1)'(ctr);
    if (sum > SMAX) return 32'sh7FFFFFFF;
    if (sum < SMIN) return 32'sh80000000;
    return sum[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
    if (en) begin
      ta <= in_tag;
      case (in_quad)
        2'd0: begin c <= in_x;  s <= in_y;  end
        2'd1: begin c <= -in_y; s <= in_x;  end
        2'd2: begin c <= -in_x; s <= -in_y; end
        default: begin c <= in_y; s <= -in_x; end
      endcase
      tb <= ta;
      pc <= PW'($signed({1'b0, radius})) * PW'(c);
      ps <= PW'($signed({1'b0, radius})) * PW'(s);
      out_tag <= tb;
      if (tb.ok) begin
        out_lon <= fin(pc, center_lon);
        out_lat <= fin(ps, center_lat);
      end else begin
        out_lon <= '0;
        out_lat <= '0;
      end
    end
  end

endmodule

[src/circular_layout_positions_unit.sv]
// ----------------------------------------------------------------------------
// circular_layout_positions_unit
// Places item number item_index of item_count items evenly on a circle.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request, in order. The pipeline is an entry register, eight
// divider stages of four quotient bits each, one CORDIC stage per iteration,
// then quadrant fold, radius multiply and round/add/saturate. The whole
// pipeline holds while a result waits at the output. Write configuration
// only while no request is in flight.
module circular_layout_positions_unit import clp_pkg::*; #(
  parameter int MAX_ITEMS     = MAX_ITEMS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // item_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // item_id, pos_lon, pos_lat, pos_alt
  output logic         m_tuser    // valid_res
);

  logic signed [31:0] center_lon, center_lat, start_altitude;
  logic [30:0]        circle_radius;
  logic [15:0]        phase_offset;
  logic [7:0]         item_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_lon     <= '0;
      center_lat     <= '0;
      circle_radius  <= '0;
      start_altitude <= '0;
      phase_offset   <= '0;
      item_count     <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_LON:   center_lon     <= cfg_wdata;
        REG_CENTER_LAT:   center_lat     <= cfg_wdata;
        REG_RADIUS:       circle_radius  <= cfg_wdata[30:0];
        REG_ALTITUDE:     start_altitude <= cfg_wdata;
        REG_PHASE_OFFSET: phase_offset   <= cfg_wdata[15:0];
        REG_ITEM_COUNT:   item_count     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic                 en;
  logic                 dv, cv;
  clp_tag_t             dtag, ctag, otag;
  logic [31:0]          dphase;
  logic [1:0]           cquad;
  logic signed [VW-1:0] cx, cy;
  logic signed [31:0]   olon, olat;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  clp_divider #(.MAX_ITEMS(MAX_ITEMS)) u_div (
    .clk, .rst, .en,
    .in_valid(s_tvalid), .item_index(s_tdata), .item_count, .phase_offset,
    .out_valid(dv), .out_tag(dtag), .out_phase(dphase)
  );

  clp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .en,
    .in_valid(dv), .in_tag(dtag), .in_phase(dphase),
    .out_valid(cv), .out_tag(ctag), .out_quad(cquad), .out_x(cx), .out_y(cy)
  );

  clp_scale u_scale (
    .clk, .rst, .en,
    .in_valid(cv), .in_tag(ctag), .in_quad(cquad), .in_x(cx), .in_y(cy),
    .radius(circle_radius), .center_lon, .center_lat,
    .out_valid(m_tvalid), .out_tag(otag), .out_lon(olon), .out_lat(olat)
  );

  assign m_tuser = otag.ok;
  assign m_tdata = otag.ok ? {start_altitude, olat, olon, otag.id} : 104'h0;

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 104'h0))
    else $error("invalid result carries nonzero data");
`endif

endmodule

[verif/circular_layout_positions_unit_test.sv]
// ----------------------------------------------------------------------------
// circular_layout_positions_unit_test
// Drives item indexes under several circle settings, predicts each placed
// position with a CORDIC model of its own, and checks results in order.
// ----------------------------------------------------------------------------
module circular_layout_positions_unit_test;
  import clp_pkg::*;

  typedef struct {
    logic        ok;
    logic [7:0]  id;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] alt;
  } placement_t;

  class placement_scoreboard;
    placement_t pending[$];
    int mismatches;
    int checked;
    logic signed [31:0] c_lon, c_lat, alt;
    logic [30:0] radius;
    logic [15:0] offset;
    logic [7:0] count;

    function void set_reg(clp_reg_t r, logic [31:0] v);
      case (r)
        REG_CENTER_LON: begin
          c_lon = v;
        end
        REG_CENTER_LAT: begin
          c_lat = v;
        end
        REG_RADIUS: begin
          radius = v[30:0];
        end
        REG_ALTITUDE: begin
          alt = v;
        end
        REG_PHASE_OFFSET: begin
          offset = v[15:0];
        end
        REG_ITEM_COUNT: begin
          count = v[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint place(longint ctr, longint v);
      longint p;
      p = ctr + ((longint'(radius) * v + (longint'(1) << 29)) >>> 30);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p;
    endfunction

    function void note_request(logic [7:0] idx);
      placement_t e;
      longint unsigned num;
      logic [31:0] phase;
      longint x, y, z, dx, dy, cv, sv;
      int n;
      n = (count > 255) ? 255 : count;
      e = '{default: '0};
      if (n != 0 && idx < n) begin
        num = ((longint'(idx) << 16) | offset) << 16;
        phase = 32'(num / n);
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(clp_atan(i));
          end else begin
            x += dx; y -= dy; z += longint'(clp_atan(i));
          end
        end
        case (phase[31:30])
          2'd0: begin cv = x;  sv = y;  end
          2'd1: begin cv = -y; sv = x;  end
          2'd2: begin cv = -x; sv = -y; end
          default: begin cv = y; sv = -x; end
        endcase
        e.ok = 1'b1;
        e.id = idx + 8'd1;
        e.lon = 32'(place(c_lon, cv));
        e.lat = 32'(place(c_lat, sv));
        e.alt = alt;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic ok, logic [103:0] d);
      placement_t e, a;
      checked++;
      a.ok = ok; a.id = d[7:0]; a.lon = d[39:8]; a.lat = d[71:40]; a.alt = d[103:72];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result ok=%0b data=%h", ok, d);
        return;
      end
      e = pending.pop_front();
      if (e.ok !== a.ok || e.id !== a.id || e.lon !== a.lon || e.lat !== a.lat ||
          e.alt !== a.alt) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp ok=%0b id=%0d lon=%h lat=%h alt=%h, ",
                    "got ok=%0b id=%0d lon=%h lat=%h alt=%h"},
                   e.ok, e.id, e.lon, e.lat, e.alt, a.ok, a.id, a.lon, a.lat, a.alt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic m_tuser;

  placement_scoreboard sb;
  bit quiet = 1'b0;
  int sent = 0;

  circular_layout_positions_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // random stall bursts on the result side
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_reg(clp_reg_t r, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  task automatic send_request(logic [7:0] idx);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= idx;
    do @(posedge clk); while (!s_tready);
    sb.note_request(idx);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] lon, logic [31:0] lat, logic [31:0] r,
                       logic [31:0] a, logic [31:0] off, logic [31:0] n);
    write_reg(REG_CENTER_LON, lon);
    write_reg(REG_CENTER_LAT, lat);
    write_reg(REG_RADIUS, r);
    write_reg(REG_ALTITUDE, a);
    write_reg(REG_PHASE_OFFSET, off);
    write_reg(REG_ITEM_COUNT, n);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] n;
    sb = new();
    sb.c_lon = 0; sb.c_lat = 0; sb.radius = 0; sb.alt = 0; sb.offset = 0; sb.count = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: one item at the center
    send_request(8'd0);
    send_request(8'd1);
    drain();
    setup(32'h0A000000, 32'hF6000000, 32'h00800000, 32'h12345678, 32'd0, 32'd4);
    for (int i = 0; i < 6; i++) send_request(8'(i));
    send_request(8'd255);
    drain();
    // extremes: huge radius saturates, full offset, count 255, count 0
    setup(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF, 32'd255);
    send_request(8'd0);
    send_request(8'd63);
    send_request(8'd127);
    send_request(8'd191);
    send_request(8'd254);
    send_request(8'd255);
    drain();
    setup(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0);
    send_request(8'd0);
    send_request(8'd200);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      n = (ph % 4 == 0) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(0, 255));
      if (ph == 11) n = 8'd255;
      setup($urandom, $urandom, (ph % 3 == 0) ? $urandom : $urandom_range(0, 32'h0FFFFFFF),
            $urandom, $urandom, n);
      if (ph == 11) quiet = 1'b1;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(0, 9) == 0) send_request(8'($urandom));
        else send_request(8'($urandom_range(0, (n == 0) ? 0 : n - 1)));
      end
      drain();
    end

    $display("Sent %0d index requests over 16 circle settings, %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

[circular_layout_positions_unit.f]
src/clp_pkg.sv
src/clp_divider.sv
src/clp_cordic.sv
src/clp_scale.sv
src/circular_layout_positions_unit.sv
verif/circular_layout_positions_unit_test.sv
